// File: rtl/srtf_pkg.sv
// Shared constants, codes and types of the SRTF multi-CPU task table.
package srtf_pkg;

    // Sizing
    localparam int NUM_CPUS    = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 20;

    localparam int PID_W  = 16;
    localparam int TIN_W  = 20;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LOAD_W = TIME_BITS + CNT_W;
    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CPUX_W = $clog2(NUM_CPUS + 1);

    // Operation codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Command item
    typedef struct packed {
        logic             kind;
        logic [1:0]       target_cpu;
        logic [PID_W-1:0] task_pid;
        logic [TIN_W-1:0] task_remaining;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [1:0] least_loaded_cpu;
        logic [2:0] first_idle_cpu;
        logic [2:0] idle_cpu_count;
        logic       pid_last_part;
        logic [1:0] status;
    } t_result;

    // One queue entry
    typedef struct packed {
        logic [PID_W-1:0]     pid;
        logic [TIME_BITS-1:0] rem_time;
    } t_entry;

    // Flags passed down the cell chain
    typedef struct packed {
        logic ahead;   // this entry sorts ahead of the new task
        logic hit;     // pid seen at or before this cell
        logic dup;     // pid seen twice at or before this cell
    } t_link;

    // Queue control from the sequencer
    typedef struct packed {
        logic                 ins_en;
        logic                 rem_en;
        logic [PID_W-1:0]     pid;
        logic [TIME_BITS-1:0] rem_time;
    } t_q_ctrl;

    // Queue status back to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [LOAD_W-1:0] load;
        logic              full;
        logic              hit;
        logic              dup;
    } t_q_stat;

endpackage

// File: rtl/srtf_cell.sv
// One queue slot: holds an entry, shifts right on insert and left on remove.
module srtf_cell (
    input  logic             i_clk,
    input  srtf_pkg::t_q_ctrl i_ctrl,
    input  logic             i_valid,
    input  srtf_pkg::t_entry i_left,
    input  srtf_pkg::t_entry i_right,
    input  srtf_pkg::t_link  i_link,
    output srtf_pkg::t_entry o_entry,
    output srtf_pkg::t_link  o_link,
    output logic             o_taken
);

    srtf_pkg::t_entry r_entry;
    srtf_pkg::t_entry n_entry;
    logic             w_match;
    logic             w_ahead;

    // Compare own entry against the command
    assign w_match = i_valid && (r_entry.pid == i_ctrl.pid);
    assign w_ahead = i_valid && ((r_entry.rem_time < i_ctrl.rem_time) ||
                     ((r_entry.rem_time == i_ctrl.rem_time) && (r_entry.pid < i_ctrl.pid)));

    // Chain flags
    assign o_link.ahead = w_ahead;
    assign o_link.hit   = i_link.hit | w_match;
    assign o_link.dup   = i_link.dup | (i_link.hit & w_match);
    assign o_taken      = w_match & ~i_link.hit;
    assign o_entry      = r_entry;

    // Next entry: keep, take new task, take left neighbor, or take right neighbor
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins_en) begin
            if (!w_ahead) begin
                if (i_link.ahead) begin
                    n_entry.pid      = i_ctrl.pid;
                    n_entry.rem_time = i_ctrl.rem_time;
                end else begin
                    n_entry = i_left;
                end
            end
        end else if (i_ctrl.rem_en) begin
            if (i_link.hit || w_match) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/srtf_queue.sv
// One CPU's sorted queue: a row of cells plus entry count and load total.
module srtf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srtf_pkg::t_q_ctrl i_ctrl,
    output srtf_pkg::t_q_stat o_stat
);

    logic [srtf_pkg::CNT_W-1:0]     r_count;
    logic [srtf_pkg::CNT_W-1:0]     n_count;
    logic [srtf_pkg::LOAD_W-1:0]    r_load;
    logic [srtf_pkg::LOAD_W-1:0]    n_load;
    logic                           w_full;
    logic                           w_ins_go;
    logic                           w_rem_go;
    logic [srtf_pkg::TIME_BITS-1:0] w_rm_time;
    srtf_pkg::t_q_ctrl              w_ctrl;
    srtf_pkg::t_entry               w_entry [srtf_pkg::QUEUE_DEPTH];
    srtf_pkg::t_link                w_link  [srtf_pkg::QUEUE_DEPTH+1];
    logic [srtf_pkg::QUEUE_DEPTH-1:0] w_taken;

    assign w_full   = (r_count == srtf_pkg::CNT_W'(srtf_pkg::QUEUE_DEPTH));
    assign w_ins_go = i_ctrl.ins_en & ~w_full;
    assign w_rem_go = i_ctrl.rem_en & w_link[srtf_pkg::QUEUE_DEPTH].hit;

    // Insert is dropped when full
    always_comb begin
        w_ctrl        = i_ctrl;
        w_ctrl.ins_en = w_ins_go;
    end

    // Head of the chain
    assign w_link[0].ahead = 1'b1;
    assign w_link[0].hit   = 1'b0;
    assign w_link[0].dup   = 1'b0;

    for (genvar i = 0; i < srtf_pkg::QUEUE_DEPTH; i++) begin : g_cell
        srtf_pkg::t_entry w_left;
        srtf_pkg::t_entry w_right;
        logic             w_valid;

        assign w_left  = (i == 0) ? w_entry[i] : w_entry[(i == 0) ? 0 : i-1];
        assign w_right = (i == srtf_pkg::QUEUE_DEPTH-1) ? w_entry[i] :
                         w_entry[(i == srtf_pkg::QUEUE_DEPTH-1) ? i : i+1];
        assign w_valid = (srtf_pkg::CNT_W'(i) < r_count);

        srtf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_valid (w_valid),
            .i_left  (w_left),
            .i_right (w_right),
            .i_link  (w_link[i]),
            .o_entry (w_entry[i]),
            .o_link  (w_link[i+1]),
            .o_taken (w_taken[i])
        );
    end

    // Time of the first matching entry (one-hot select)
    always_comb begin
        w_rm_time = '0;
        for (int i = 0; i < srtf_pkg::QUEUE_DEPTH; i++) begin
            if (w_taken[i]) begin
                w_rm_time = w_rm_time | w_entry[i].rem_time;
            end
        end
    end

    // Count and running load
    always_comb begin
        n_count = r_count;
        n_load  = r_load;
        if (w_ins_go) begin
            n_count = r_count + srtf_pkg::CNT_W'(1);
            n_load  = r_load + srtf_pkg::LOAD_W'(i_ctrl.rem_time);
        end else if (w_rem_go) begin
            n_count = r_count - srtf_pkg::CNT_W'(1);
            n_load  = r_load - srtf_pkg::LOAD_W'(w_rm_time);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_load  <= '0;
        end else begin
            r_count <= n_count;
            r_load  <= n_load;
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.load  = r_load;
    assign o_stat.full  = w_full;
    assign o_stat.hit   = w_link[srtf_pkg::QUEUE_DEPTH].hit;
    assign o_stat.dup   = w_link[srtf_pkg::QUEUE_DEPTH].dup;

endmodule

// File: rtl/srtf_multi_cpu_task_table.sv
// Top level: command sequencer, per-CPU queues and summary reduction.
//
//   channel   ports                          handshake
//   command   start, busy, i_cmd             taken when start=1 and busy=0
//   result    o_done, o_result               one-cycle strobe, no back-pressure
//   config    i_cfg_we, i_cfg_wdata          written when i_cfg_we=1
//
// Each command passes through accept, queue update in the cell chains, pid
// match scan down the chains and summary reduction across CPUs. o_done pulses in
// the cycle after the reduction, when busy is already low again.
// The sequencer handles one command at a time and takes no new one while busy.
// Reset is synchronous; it empties all queues and sets active_cpus to 4. No
// clearing pass is needed.
module srtf_multi_cpu_task_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  srtf_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output srtf_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_UPD   = 4'b0010,
        S_MATCH = 4'b0100,
        S_RED   = 4'b1000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    srtf_pkg::t_cmd              r_cmd;
    logic [2:0]                  r_active;
    logic [1:0]                  r_status;
    logic [1:0]                  n_status;
    logic [srtf_pkg::NUM_CPUS-1:0] r_q_hit;
    logic [srtf_pkg::NUM_CPUS-1:0] r_q_dup;
    logic                        r_done;
    srtf_pkg::t_result           r_result;
    srtf_pkg::t_result           n_result;
    logic [srtf_pkg::CPUX_W-1:0] w_act;
    logic                        w_tgt_ok;
    srtf_pkg::t_q_stat           w_stat [srtf_pkg::NUM_CPUS];
    logic [srtf_pkg::NUM_CPUS-1:0] w_hit;
    logic [srtf_pkg::NUM_CPUS-1:0] w_dup;

    // Effective number of active CPUs
    always_comb begin
        if (r_active == 3'd0) begin
            w_act = srtf_pkg::CPUX_W'(1);
        end else if (32'(r_active) > srtf_pkg::NUM_CPUS) begin
            w_act = srtf_pkg::CPUX_W'(srtf_pkg::NUM_CPUS);
        end else begin
            w_act = srtf_pkg::CPUX_W'(r_active);
        end
    end

    assign w_tgt_ok = (32'(r_cmd.target_cpu) < srtf_pkg::NUM_CPUS);

    // Per-CPU queues
    for (genvar q = 0; q < srtf_pkg::NUM_CPUS; q++) begin : g_queue
        srtf_pkg::t_q_ctrl w_ctrl;
        logic              w_sel;

        assign w_sel           = (32'(r_cmd.target_cpu) == q) && (r_state == S_UPD);
        assign w_ctrl.ins_en   = w_sel && (r_cmd.kind == srtf_pkg::KIND_INSERT);
        assign w_ctrl.rem_en   = w_sel && (r_cmd.kind == srtf_pkg::KIND_REMOVE);
        assign w_ctrl.pid      = r_cmd.task_pid;
        assign w_ctrl.rem_time = srtf_pkg::TIME_BITS'(r_cmd.task_remaining);

        srtf_queue u_queue (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .o_stat  (w_stat[q])
        );

        assign w_hit[q] = w_stat[q].hit;
        assign w_dup[q] = w_stat[q].dup;
    end

    // Status of the operation, taken from the target queue before update
    always_comb begin
        n_status = srtf_pkg::ST_DONE;
        if (!w_tgt_ok) begin
            n_status = (r_cmd.kind == srtf_pkg::KIND_REMOVE) ?
                       srtf_pkg::ST_NOT_FOUND : srtf_pkg::ST_FULL;
        end else begin
            for (int q = 0; q < srtf_pkg::NUM_CPUS; q++) begin
                if (32'(r_cmd.target_cpu) == q) begin
                    if (r_cmd.kind == srtf_pkg::KIND_INSERT) begin
                        n_status = w_stat[q].full ? srtf_pkg::ST_FULL : srtf_pkg::ST_DONE;
                    end else begin
                        n_status = w_stat[q].hit ? srtf_pkg::ST_DONE
                                                 : srtf_pkg::ST_NOT_FOUND;
                    end
                end
            end
        end
    end

    // Summary over active CPUs
    always_comb begin
        logic [srtf_pkg::CPU_W-1:0]  best;
        logic [srtf_pkg::LOAD_W-1:0] best_load;
        logic [srtf_pkg::CPUX_W-1:0] first_idle;
        logic [srtf_pkg::CPUX_W-1:0] idle_cnt;
        logic                        seen;
        logic                        multi;

        best       = '0;
        best_load  = '0;
        first_idle = srtf_pkg::CPUX_W'(srtf_pkg::NUM_CPUS);
        idle_cnt   = '0;
        seen       = 1'b0;
        multi      = 1'b0;
        for (int q = 0; q < srtf_pkg::NUM_CPUS; q++) begin
            if (32'(w_act) > q) begin
                if (q == 0 || w_stat[q].load < best_load) begin
                    best      = srtf_pkg::CPU_W'(q);
                    best_load = w_stat[q].load;
                end
                if (w_stat[q].count == '0) begin
                    idle_cnt = idle_cnt + srtf_pkg::CPUX_W'(1);
                    if (32'(first_idle) == srtf_pkg::NUM_CPUS) begin
                        first_idle = srtf_pkg::CPUX_W'(q);
                    end
                end
                if (r_q_dup[q] || (r_q_hit[q] && seen)) begin
                    multi = 1'b1;
                end
                if (r_q_hit[q]) begin
                    seen = 1'b1;
                end
            end
        end
        n_result.least_loaded_cpu = 2'(best);
        n_result.first_idle_cpu   = 3'(first_idle);
        n_result.idle_cpu_count   = 3'(idle_cnt);
        n_result.pid_last_part    = ~multi;
        n_result.status           = r_status;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_UPD;
            S_UPD:   n_state = S_MATCH;
            S_MATCH: n_state = S_RED;
            S_RED:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 3'd4;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_RED);
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_UPD) begin
            r_status <= n_status;
        end
        if (r_state == S_MATCH) begin
            r_q_hit <= w_hit;
            r_q_dup <= w_dup;
        end
        if (r_state == S_RED) begin
            r_result <= n_result;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
